// ----- hw/rtl/aled_pkg.sv -----
// Shared types and constants of the addressable LED chain driver.
`default_nettype none

package aled_pkg;

   // Chain geometry
   localparam int LED_COUNT    = 64;
   localparam int RESET_SLOTS  = 1;
   localparam int BITS_PER_LED = 24;
   localparam int TOTAL_SLOTS  = RESET_SLOTS + LED_COUNT + RESET_SLOTS;
   localparam int SLOT_W       = $clog2(TOTAL_SLOTS);
   localparam int LED_AW       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int BIT_W        = $clog2(BITS_PER_LED);
   localparam int CH_COUNT     = 3;

   // Register file
   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_ONE_HIGH  = 2'd0;
   localparam logic [1:0] REG_ZERO_HIGH = 2'd1;
   localparam logic [1:0] REG_PERIOD    = 2'd2;
   localparam logic [7:0] ONE_HIGH_RST  = 8'd58;
   localparam logic [7:0] ZERO_HIGH_RST = 8'd25;
   localparam logic [7:0] PERIOD_RST    = 8'd90;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_START = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] one_high;
      logic [7:0] zero_high;
      logic [7:0] bit_period;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] channel_mask;
   } item_type;

   typedef struct packed {
      logic              wr_en;
      logic              clr;
      logic [LED_AW-1:0] addr;
      logic [2:0]        mask;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
   } wr_cmd_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/aled_csr.sv -----
// Timing registers of the LED driver behind a simple register port.
`default_nettype none

module aled_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [aled_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output aled_pkg::cfg_type               cfg
);
   import aled_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_go;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_go      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // Decode the write; addresses beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_go) begin
         case (reg_idx)
            REG_ONE_HIGH:  cfg_in.one_high   = csr_pwdata[7:0];
            REG_ZERO_HIGH: cfg_in.zero_high  = csr_pwdata[7:0];
            REG_PERIOD:    cfg_in.bit_period = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high   <= ONE_HIGH_RST;
         cfg_ff.zero_high  <= ZERO_HIGH_RST;
         cfg_ff.bit_period <= PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_ONE_HIGH:  csr_prdata = {24'd0, cfg_ff.one_high};
         REG_ZERO_HIGH: csr_prdata = {24'd0, cfg_ff.zero_high};
         REG_PERIOD:    csr_prdata = {24'd0, cfg_ff.bit_period};
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/aled_store.sv -----
// Color store: one byte memory per channel, per-entry valid bits, registered read.
`default_nettype none

module aled_store (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire aled_pkg::wr_cmd_type       wr_cmd,
   input  wire logic [aled_pkg::LED_AW-1:0] rd_addr,
   output logic [23:0]                     rd_word
);
   import aled_pkg::*;

   logic [7:0]                         color_mem_ff [CH_COUNT][LED_COUNT];
   logic [CH_COUNT-1:0][LED_COUNT-1:0] vld_ff, vld_in;
   logic [CH_COUNT-1:0][7:0]           wr_byte;
   logic [CH_COUNT-1:0][7:0]           rd_mem_ff;
   logic [CH_COUNT-1:0][7:0]           byp_ff, byp_in;
   logic [CH_COUNT-1:0]                use_mem_ff, use_mem_in;
   logic [CH_COUNT-1:0]                hit;
   logic [CH_COUNT-1:0][7:0]           chan;

   // Channel 0 red, 1 green, 2 blue, matching the mask bits
   assign wr_byte = {wr_cmd.blue, wr_cmd.green, wr_cmd.red};

   // Valid bits: clear drops all at once, a write marks its channels
   always_comb begin
      vld_in = vld_ff;
      if (wr_cmd.clr) begin
         vld_in = '0;
      end else if (wr_cmd.wr_en) begin
         for (int c = 0; c < CH_COUNT; c++) begin
            if (wr_cmd.mask[c]) vld_in[c][wr_cmd.addr] = 1'b1;
         end
      end
   end

   // Bypass a write or clear that lands in the same cycle as the read
   always_comb begin
      for (int c = 0; c < CH_COUNT; c++) begin
         hit[c]        = wr_cmd.wr_en && wr_cmd.mask[c] && (wr_cmd.addr == rd_addr);
         use_mem_in[c] = vld_ff[c][rd_addr] && !wr_cmd.clr && !hit[c];
         byp_in[c]     = hit[c] ? wr_byte[c] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         use_mem_ff <= '0;
      end else begin
         vld_ff     <= vld_in;
         use_mem_ff <= use_mem_in;
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      for (int c = 0; c < CH_COUNT; c++) begin
         if (wr_cmd.wr_en && wr_cmd.mask[c]) color_mem_ff[c][wr_cmd.addr] <= wr_byte[c];
         rd_mem_ff[c] <= color_mem_ff[c][rd_addr];
         byp_ff[c]    <= byp_in[c];
      end
   end

   always_comb begin
      for (int c = 0; c < CH_COUNT; c++) begin
         chan[c] = use_mem_ff[c] ? rd_mem_ff[c] : byp_ff[c];
      end
   end

   // Word layout is green, red, blue from the top
   assign rd_word = {chan[1], chan[0], chan[2]};

endmodule

`default_nettype wire

// ----- hw/rtl/aled_seq.sv -----
// Frame sequencer: slot, bit and timer counters, line level and store commands.
`default_nettype none

module aled_seq (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire aled_pkg::item_type          item,
   input  wire aled_pkg::cfg_type           cfg,
   input  wire logic [23:0]                 rd_word,
   output aled_pkg::wr_cmd_type             wr_cmd,
   output logic [aled_pkg::LED_AW-1:0]      rd_addr,
   output aled_pkg::result_type             result
);
   import aled_pkg::*;

   logic              sending_ff, sending_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [BIT_W-1:0]  bitpos_ff, bitpos_in;
   logic [7:0]        tick_ff, tick_in;
   logic              in_led;
   logic              bit_sel;
   logic [7:0]        high_cnt;
   logic [7:0]        period;
   logic [7:0]        tick_inc;
   logic              level;
   logic              done;

   // High time of the current bit; reset slots stay low
   assign in_led   = (slot_ff >= SLOT_W'(RESET_SLOTS)) &&
                     (slot_ff < SLOT_W'(RESET_SLOTS + LED_COUNT));
   assign bit_sel  = rd_word[BIT_W'(BITS_PER_LED - 1) - bitpos_ff];
   assign high_cnt = in_led ? (bit_sel ? cfg.one_high : cfg.zero_high) : 8'd0;
   assign period   = (cfg.bit_period == 8'd0) ? 8'd1 : cfg.bit_period;
   assign tick_inc = tick_ff + 8'd1;

   // Store commands straight from the item
   always_comb begin
      wr_cmd.wr_en = advance && (item.kind == KIND_WRITE) &&
                     (32'(item.led_index) < 32'(LED_COUNT));
      wr_cmd.clr   = advance && (item.kind == KIND_CLEAR);
      wr_cmd.addr  = LED_AW'(item.led_index);
      wr_cmd.mask  = item.channel_mask;
      wr_cmd.red   = item.red;
      wr_cmd.green = item.green;
      wr_cmd.blue  = item.blue;
   end

   // Advance the frame counters
   always_comb begin
      sending_in = sending_ff;
      slot_in    = slot_ff;
      bitpos_in  = bitpos_ff;
      tick_in    = tick_ff;
      level      = 1'b0;
      done       = 1'b0;
      if (advance) begin
         case (item.kind)
            KIND_START: begin
               if (!sending_ff) begin
                  sending_in = 1'b1;
                  slot_in    = '0;
                  bitpos_in  = '0;
                  tick_in    = 8'd0;
               end
            end
            KIND_TICK: begin
               if (sending_ff) begin
                  level   = (tick_ff < high_cnt);
                  tick_in = tick_inc;
                  if (tick_inc >= period) begin
                     tick_in = 8'd0;
                     if (bitpos_ff == BIT_W'(BITS_PER_LED - 1)) begin
                        bitpos_in = '0;
                        if (slot_ff == SLOT_W'(TOTAL_SLOTS - 1)) begin
                           slot_in    = '0;
                           sending_in = 1'b0;
                           done       = 1'b1;
                        end else begin
                           slot_in = slot_ff + SLOT_W'(1);
                        end
                     end else begin
                        bitpos_in = bitpos_ff + BIT_W'(1);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         slot_ff    <= '0;
         bitpos_ff  <= '0;
         tick_ff    <= 8'd0;
      end else begin
         sending_ff <= sending_in;
         slot_ff    <= slot_in;
         bitpos_ff  <= bitpos_in;
         tick_ff    <= tick_in;
      end
   end

   // Prefetch the word of the slot that the next item sees
   assign rd_addr = LED_AW'(slot_in - SLOT_W'(RESET_SLOTS));

   assign result.line_level = level;
   assign result.busy_res   = sending_in;
   assign result.frame_done = done;

endmodule

`default_nettype wire

// ----- hw/rtl/addressable_led_chain_driver.sv -----
// An accepted word is registered, then its result word when the result register is free.
// Throughput: one word per cycle unless the result channel stalls; the store is read
// ahead from the address of the slot the next word will see, so ticks run back to back.
// Reset: synchronous, active high; clears counters, handshake state and the store's
// valid bits (the store then reads as zero), and loads the timing registers' defaults.
`default_nettype none

module addressable_led_chain_driver (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Input channel
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // [7:0] led_index, [15:8] red, [23:16] green, [31:24] blue, [34:32] channel_mask
   input  wire logic [39:0]                req_tdata,
   // [1:0] kind
   input  wire logic [1:0]                 req_tuser,
   // Result channel
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [0] line_level, [1] busy_res
   output logic [7:0]                      rsp_tdata,
   // frame_done
   output logic                            rsp_tlast,
   // Register port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [aled_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import aled_pkg::*;

   logic                in_vld_ff, in_vld_in;
   item_type            item_ff;
   logic                rsp_vld_ff, rsp_vld_in;
   result_type          rsp_ff;
   result_type          result;
   logic                advance;
   logic                req_go;
   cfg_type             cfg;
   wr_cmd_type          wr_cmd;
   logic [LED_AW-1:0]   rd_addr;
   logic [23:0]         rd_word;

   // Handshake: the stage moves on when the result register is free
   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_go     = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_go)       in_vld_in = 1'b1;
      else if (advance) in_vld_in = 1'b0;
      rsp_vld_in = rsp_vld_ff;
      if (advance)         rsp_vld_in = 1'b1;
      else if (rsp_tready) rsp_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Capture the input word and the result
   always_ff @(posedge clock) begin
      if (req_go) begin
         item_ff.kind         <= kind_type'(req_tuser[1:0]);
         item_ff.led_index    <= req_tdata[7:0];
         item_ff.red          <= req_tdata[15:8];
         item_ff.green        <= req_tdata[23:16];
         item_ff.blue         <= req_tdata[31:24];
         item_ff.channel_mask <= req_tdata[34:32];
      end
      if (advance) rsp_ff <= result;
   end

   aled_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   aled_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .rd_word (rd_word),
      .wr_cmd  (wr_cmd),
      .rd_addr (rd_addr),
      .result  (result)
   );

   aled_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_cmd  (wr_cmd),
      .rd_addr (rd_addr),
      .rd_word (rd_word)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.busy_res, rsp_ff.line_level};
   assign rsp_tlast  = rsp_ff.frame_done;

endmodule

`default_nettype wire

// ----- hw/rtl/aled_chk.sv -----
// Port-level checks of the LED driver and their binding to the top level.
`default_nettype none

module aled_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   // No result word right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A high line level only comes while a frame is running
   a_level_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("line high while not busy");

   // The frame end word reports the frame as finished
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[1] && !rsp_tdata[0])
      else $error("frame done while still busy or line high");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

endmodule

bind addressable_led_chain_driver aled_chk u_chk (.*);

`default_nettype wire
